// ===== rtl/core/two_level_direct_mapped_cache_unit_defines.svh =====
// assertion macros for the two-level cache unit
// used by modules that check their own control logic; needs clk and rst in scope
`ifndef TWO_LEVEL_DIRECT_MAPPED_CACHE_UNIT_DEFINES_SVH
`define TWO_LEVEL_DIRECT_MAPPED_CACHE_UNIT_DEFINES_SVH

// same-cycle implication
`define TLDMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TLDMC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tldmc_pkg.sv =====
// shared types and constants for the two-level cache unit
// no dependencies
package tldmc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int COST_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_L1_RD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_WR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L2_RD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L2_WR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAM_RD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRAM_WR = 3'd5;

  typedef enum logic [2:0] {
    CP_L2_DRAM,
    CP_DRAM_L2,
    CP_L2_TMP,
    CP_L1_L2,
    CP_TMP_L1
  } cp_kind_t;

  typedef struct packed {
    logic     latch;
    logic     l1_eval;
    logic     op_set;
    logic     op_victim;
    logic     l2_eval;
    logic     cp_start;
    cp_kind_t cp_kind;
    logic     word_go;
    logic     resp_load;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic l1_hit;
    logic l1_vdirty;
    logic l2_hit;
    logic l2_vdirty;
    logic op_victim;
    logic cp_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/tldmc_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tldmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tldmc_dp.sv =====
// datapath: cache data, tag rams, dram, block copy engine, costs and output register
// depends on tldmc_pkg and tldmc_ram
module tldmc_dp #(
  parameter int OFFSET_BITS    = 6,
  parameter int L1_INDEX_WIDTH = 8,
  parameter int L2_INDEX_WIDTH = 9,
  parameter int DRAM_ADDR_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tldmc_pkg::cmd_t                   cmd,
  output tldmc_pkg::status_t                st,
  input  logic                              in_wr,
  input  logic [19:0]                       in_addr,
  input  logic [31:0]                       in_wdata,
  input  logic                              cfg_we,
  input  logic [tldmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tldmc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [31:0]                       read_data,
  output logic                              l1_hit,
  output logic                              l2_hit,
  output logic [tldmc_pkg::COST_W-1:0]      access_cost,
  output logic [31:0]                       total_time
);

  localparam int WIDX  = OFFSET_BITS - 2;
  localparam int WPB   = 1 << WIDX;
  localparam int BLKW  = DRAM_ADDR_BITS - OFFSET_BITS;
  localparam int L1TW  = BLKW - L1_INDEX_WIDTH;
  localparam int L2TW  = BLKW - L2_INDEX_WIDTH;
  localparam int DWA   = DRAM_ADDR_BITS - 2;
  localparam int L1MW  = L1TW + 2;
  localparam int L2MW  = L2TW + 2;
  localparam int CW    = tldmc_pkg::COST_W;
  localparam int RW    = tldmc_pkg::CFG_DATA_W;

  // configuration
  logic [RW-1:0] c_l1_rd, c_l1_wr, c_l2_rd, c_l2_wr, c_dram_rd, c_dram_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_l1_rd   <= RW'(1);
      c_l1_wr   <= RW'(1);
      c_l2_rd   <= RW'(10);
      c_l2_wr   <= RW'(10);
      c_dram_rd <= RW'(100);
      c_dram_wr <= RW'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tldmc_pkg::REG_L1_RD:   c_l1_rd   <= cfg_data;
        tldmc_pkg::REG_L1_WR:   c_l1_wr   <= cfg_data;
        tldmc_pkg::REG_L2_RD:   c_l2_rd   <= cfg_data;
        tldmc_pkg::REG_L2_WR:   c_l2_wr   <= cfg_data;
        tldmc_pkg::REG_DRAM_RD: c_dram_rd <= cfg_data;
        tldmc_pkg::REG_DRAM_WR: c_dram_wr <= cfg_data;
        default: ;
      endcase
    end
  end

  // item and operation registers
  logic                      item_wr;
  logic [DRAM_ADDR_BITS-1:0] item_addr;
  logic [31:0]               item_wdata;
  logic [BLKW-1:0]           op_blk;
  logic                      op_victim;
  logic                      l1_hit_r, l1_vd, l2_hit_r;
  logic [L1TW-1:0]           l1_vtag;
  logic [L2TW-1:0]           l2_vtag;
  logic [CW-1:0]             cost;

  logic [L1_INDEX_WIDTH-1:0] l1_idx;
  logic [L1TW-1:0]           l1_tag;
  logic [WIDX-1:0]           word;
  logic [BLKW-1:0]           item_blk;
  logic [L2_INDEX_WIDTH-1:0] l2_idx;
  logic [L2TW-1:0]           l2_tag;

  assign l1_idx   = item_addr[OFFSET_BITS +: L1_INDEX_WIDTH];
  assign l1_tag   = item_addr[DRAM_ADDR_BITS-1 -: L1TW];
  assign word     = item_addr[2 +: WIDX];
  assign item_blk = item_addr[DRAM_ADDR_BITS-1:OFFSET_BITS];
  assign l2_idx   = op_blk[L2_INDEX_WIDTH-1:0];
  assign l2_tag   = op_blk[BLKW-1 -: L2TW];

  // clearing pass
  logic           clearing;
  logic [DWA-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + DWA'(1);
      if (&clr_cnt) begin
        clearing <= 1'b0;
      end
    end
  end

  // copy engine
  logic            cp_active, cp_wv, cp_done;
  logic [WIDX:0]   cp_rcnt;
  logic [WIDX-1:0] cp_widx, cp_ridx;

  assign cp_ridx = cp_rcnt[WIDX-1:0];
  assign cp_done = cp_wv && (&cp_widx);

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_active <= 1'b0;
      cp_wv     <= 1'b0;
      cp_rcnt   <= '0;
    end else begin
      cp_wv <= cp_active && !cp_rcnt[WIDX];
      if (cmd.cp_start) begin
        cp_active <= 1'b1;
        cp_rcnt   <= '0;
      end else begin
        if (cp_active && !cp_rcnt[WIDX]) begin
          cp_rcnt <= cp_rcnt + (WIDX+1)'(1);
        end
        if (cp_done) begin
          cp_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_widx <= cp_ridx;
  end

  // memories
  logic [L1MW-1:0] l1m_rdata, l1m_wdata;
  logic [L2MW-1:0] l2m_rdata, l2m_wdata;
  logic            l1m_we, l2m_we;
  logic [31:0]     l1d_rdata, l2d_rdata, dram_rdata, tmp_rdata;
  logic [31:0]     l1d_wdata, l2d_wdata, dram_wdata;
  logic            l1d_we, l2d_we, dram_we, tmp_we;
  logic [L1_INDEX_WIDTH+WIDX-1:0] l1d_raddr, l1d_waddr;
  logic [DWA-1:0]  dram_waddr;
  logic            l1m_valid, l1m_hit, l2m_hit, l2m_vdirty;

  assign l1m_valid  = l1m_rdata[L1MW-1];
  assign l1m_hit    = l1m_valid && (l1m_rdata[L1TW-1:0] == l1_tag);
  assign l2m_hit    = l2m_rdata[L2MW-1] && (l2m_rdata[L2TW-1:0] == l2_tag);
  assign l2m_vdirty = l2m_rdata[L2MW-1] && l2m_rdata[L2MW-2] && !l2m_hit;

  assign l1m_we    = clearing || cmd.word_go;
  assign l1m_wdata = clearing ? '0 : {1'b1, item_wr || (l1_hit_r && l1_vd), l1_tag};
  assign l2m_we    = clearing || cmd.l2_eval;
  assign l2m_wdata = clearing ? '0 :
                     {1'b1, op_victim || (l2m_hit && l2m_rdata[L2MW-2]), l2_tag};

  tldmc_ram #(.WIDTH(L1MW), .DEPTH(1 << L1_INDEX_WIDTH)) u_l1_meta (
    .clk  (clk),
    .we   (l1m_we),
    .waddr(clearing ? clr_cnt[L1_INDEX_WIDTH-1:0] : l1_idx),
    .wdata(l1m_wdata),
    .raddr(l1_idx),
    .rdata(l1m_rdata)
  );

  tldmc_ram #(.WIDTH(L2MW), .DEPTH(1 << L2_INDEX_WIDTH)) u_l2_meta (
    .clk  (clk),
    .we   (l2m_we),
    .waddr(clearing ? clr_cnt[L2_INDEX_WIDTH-1:0] : l2_idx),
    .wdata(l2m_wdata),
    .raddr(l2_idx),
    .rdata(l2m_rdata)
  );

  assign l1d_raddr = {l1_idx, (cmd.cp_kind == tldmc_pkg::CP_L1_L2) ? cp_ridx : word};
  assign l1d_we    = (cp_wv && cmd.cp_kind == tldmc_pkg::CP_TMP_L1) || (cmd.word_go && item_wr);
  assign l1d_waddr = {l1_idx, cmd.word_go ? word : cp_widx};
  assign l1d_wdata = cmd.word_go ? item_wdata : tmp_rdata;

  tldmc_ram #(.WIDTH(32), .DEPTH((1 << L1_INDEX_WIDTH) * WPB)) u_l1_data (
    .clk  (clk),
    .we   (l1d_we),
    .waddr(l1d_waddr),
    .wdata(l1d_wdata),
    .raddr(l1d_raddr),
    .rdata(l1d_rdata)
  );

  assign l2d_we    = cp_wv && (cmd.cp_kind == tldmc_pkg::CP_DRAM_L2 ||
                               cmd.cp_kind == tldmc_pkg::CP_L1_L2);
  assign l2d_wdata = (cmd.cp_kind == tldmc_pkg::CP_DRAM_L2) ? dram_rdata : l1d_rdata;

  tldmc_ram #(.WIDTH(32), .DEPTH((1 << L2_INDEX_WIDTH) * WPB)) u_l2_data (
    .clk  (clk),
    .we   (l2d_we),
    .waddr({l2_idx, cp_widx}),
    .wdata(l2d_wdata),
    .raddr({l2_idx, cp_ridx}),
    .rdata(l2d_rdata)
  );

  assign dram_we    = clearing || (cp_wv && cmd.cp_kind == tldmc_pkg::CP_L2_DRAM);
  assign dram_waddr = clearing ? clr_cnt : {l2_vtag, l2_idx, cp_widx};
  assign dram_wdata = clearing ? '0 : l2d_rdata;

  tldmc_ram #(.WIDTH(32), .DEPTH(1 << DWA)) u_dram (
    .clk  (clk),
    .we   (dram_we),
    .waddr(dram_waddr),
    .wdata(dram_wdata),
    .raddr({op_blk, cp_ridx}),
    .rdata(dram_rdata)
  );

  assign tmp_we = cp_wv && cmd.cp_kind == tldmc_pkg::CP_L2_TMP;

  tldmc_ram #(.WIDTH(32), .DEPTH(WPB)) u_tmp (
    .clk  (clk),
    .we   (tmp_we),
    .waddr(cp_widx),
    .wdata(l2d_rdata),
    .raddr(cp_ridx),
    .rdata(tmp_rdata)
  );

  // item, lookup and cost registers
  logic [CW-1:0] l2_add, l1_add;

  assign l2_add = (l2m_hit ? CW'(0) : CW'(c_dram_rd)) + (l2m_vdirty ? CW'(c_dram_wr) : CW'(0)) +
                  (op_victim ? CW'(c_l2_wr) : CW'(c_l2_rd));
  assign l1_add = item_wr ? CW'(c_l1_wr) : CW'(c_l1_rd);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_wr    <= in_wr;
      item_addr  <= DRAM_ADDR_BITS'({in_addr[19:2], 2'b00});
      item_wdata <= in_wdata;
      cost       <= '0;
      l2_hit_r   <= 1'b0;
    end
    if (cmd.l1_eval) begin
      l1_hit_r <= l1m_hit;
      l1_vd    <= l1m_valid && l1m_rdata[L1MW-2];
      l1_vtag  <= l1m_rdata[L1TW-1:0];
    end
    if (cmd.op_set) begin
      op_blk    <= cmd.op_victim ? {l1_vtag, l1_idx} : item_blk;
      op_victim <= cmd.op_victim;
    end
    if (cmd.l2_eval) begin
      l2_vtag <= l2m_rdata[L2TW-1:0];
      cost    <= cost + l2_add;
      if (!op_victim) begin
        l2_hit_r <= l2m_hit;
      end
    end
    if (cmd.word_go) begin
      cost <= cost + l1_add;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      total_time <= '0;
    end else if (cmd.resp_load) begin
      out_valid   <= 1'b1;
      total_time  <= total_time + 32'(cost);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      read_data   <= item_wr ? 32'd0 : l1d_rdata;
      l1_hit      <= l1_hit_r;
      l2_hit      <= l2_hit_r;
      access_cost <= cost;
    end
  end

  always_comb begin
    st.clearing  = clearing;
    st.l1_hit    = l1m_hit;
    st.l1_vdirty = l1_vd;
    st.l2_hit    = l2m_hit;
    st.l2_vdirty = l2m_vdirty;
    st.op_victim = op_victim;
    st.cp_done   = cp_done;
    st.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== rtl/core/tldmc_ctrl.sv =====
// controller state machine sequencing lookups, block copies and the result
// depends on tldmc_pkg and the assertion macro header
`include "two_level_direct_mapped_cache_unit_defines.svh"

module tldmc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tldmc_pkg::status_t st,
  output tldmc_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE,
    L1_RD,
    L1_EV,
    L2_RD,
    L2_EV,
    COPY,
    OP_VICT,
    WORD,
    RESP
  } state_t;

  state_t               state, state_next;
  logic                 cp_start;
  tldmc_pkg::cp_kind_t  cp_kind, cp_kind_next;
  logic                 go_copy;

  assign in_ready = (state == IDLE) && !st.clearing;

  always_comb begin
    state_next   = state;
    cp_kind_next = cp_kind;
    go_copy      = 1'b0;
    unique case (state)
      IDLE:    if (in_valid && in_ready) state_next = L1_RD;
      L1_RD:   state_next = L1_EV;
      L1_EV:   state_next = st.l1_hit ? WORD : L2_RD;
      L2_RD:   state_next = L2_EV;
      L2_EV: begin
        go_copy = 1'b1;
        if (st.l2_vdirty) begin
          cp_kind_next = tldmc_pkg::CP_L2_DRAM;
        end else if (!st.l2_hit && !st.op_victim) begin
          cp_kind_next = tldmc_pkg::CP_DRAM_L2;
        end else if (st.op_victim) begin
          cp_kind_next = tldmc_pkg::CP_L1_L2;
        end else begin
          cp_kind_next = tldmc_pkg::CP_L2_TMP;
        end
      end
      COPY: begin
        if (st.cp_done) begin
          unique case (cp_kind)
            tldmc_pkg::CP_L2_DRAM: begin
              go_copy      = 1'b1;
              cp_kind_next = st.op_victim ? tldmc_pkg::CP_L1_L2 : tldmc_pkg::CP_DRAM_L2;
            end
            tldmc_pkg::CP_DRAM_L2: begin
              go_copy      = 1'b1;
              cp_kind_next = tldmc_pkg::CP_L2_TMP;
            end
            tldmc_pkg::CP_L2_TMP: begin
              if (st.l1_vdirty) begin
                state_next = OP_VICT;
              end else begin
                go_copy      = 1'b1;
                cp_kind_next = tldmc_pkg::CP_TMP_L1;
              end
            end
            tldmc_pkg::CP_L1_L2: begin
              go_copy      = 1'b1;
              cp_kind_next = tldmc_pkg::CP_TMP_L1;
            end
            tldmc_pkg::CP_TMP_L1: state_next = WORD;
            default: state_next = IDLE;
          endcase
        end
      end
      OP_VICT: state_next = L2_RD;
      WORD:    state_next = RESP;
      RESP:    if (st.out_free) state_next = IDLE;
      default: state_next = IDLE;
    endcase
    if (go_copy) begin
      state_next = COPY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      cp_start <= 1'b0;
      cp_kind  <= tldmc_pkg::CP_L2_TMP;
    end else begin
      state    <= state_next;
      cp_start <= go_copy;
      cp_kind  <= cp_kind_next;
    end
  end

  always_comb begin
    cmd.latch     = in_valid && in_ready;
    cmd.l1_eval   = (state == L1_EV);
    cmd.op_set    = (state == L1_EV) || (state == OP_VICT);
    cmd.op_victim = (state == OP_VICT);
    cmd.l2_eval   = (state == L2_EV);
    cmd.cp_start  = cp_start;
    cmd.cp_kind   = cp_kind;
    cmd.word_go   = (state == WORD);
    cmd.resp_load = (state == RESP) && st.out_free;
  end

  `TLDMC_ASSERT_IMP(a_no_accept_in_clear, st.clearing, !cmd.latch, "item taken during clear")
  `TLDMC_ASSERT_IMP(a_done_in_copy, st.cp_done, state == COPY, "copy ended outside copy state")
  `TLDMC_ASSERT_NXT(a_accept_to_lookup, cmd.latch, state == L1_RD, "accept did not start lookup")
  `TLDMC_ASSERT_IMP(a_start_in_copy, cp_start, state == COPY, "copy started outside copy state")

endmodule

// ===== rtl/core/two_level_direct_mapped_cache_unit.sv =====
// two-level direct-mapped write-back cache unit over an internal dram, one access at a time
// l1 hit: the access steps through L1_RD, L1_EV, WORD and RESP, then back to IDLE
// a miss runs two to six block copies; a full output register holds the result
// after reset a clearing pass zeroes every dram word and the tag rams
// depends on tldmc_pkg, tldmc_ctrl, tldmc_dp
module two_level_direct_mapped_cache_unit #(
  parameter int OFFSET_BITS    = 6,
  parameter int L1_INDEX_WIDTH = 8,
  parameter int L2_INDEX_WIDTH = 9,
  parameter int DRAM_ADDR_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [55:0]                      s_tdata,  // address, write_data, zero fill
  input  logic                             s_tuser,  // cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [87:0]                      m_tdata,  // read_data, l1_hit, l2_hit, access_cost, total_time
  input  logic                             cfg_we,
  input  logic [tldmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tldmc_pkg::CFG_DATA_W-1:0] cfg_data
);

  tldmc_pkg::cmd_t    cmd;
  tldmc_pkg::status_t st;
  logic [31:0]        read_data, total_time;
  logic               l1_hit, l2_hit;
  logic [tldmc_pkg::COST_W-1:0] access_cost;

  tldmc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .st      (st),
    .cmd     (cmd)
  );

  tldmc_dp #(
    .OFFSET_BITS   (OFFSET_BITS),
    .L1_INDEX_WIDTH(L1_INDEX_WIDTH),
    .L2_INDEX_WIDTH(L2_INDEX_WIDTH),
    .DRAM_ADDR_BITS(DRAM_ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_wr      (s_tuser),
    .in_addr    (s_tdata[19:0]),
    .in_wdata   (s_tdata[51:20]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .read_data  (read_data),
    .l1_hit     (l1_hit),
    .l2_hit     (l2_hit),
    .access_cost(access_cost),
    .total_time (total_time)
  );

  assign m_tdata = {6'd0, total_time, access_cost, l2_hit, l1_hit, read_data};

endmodule
